/* sv/image_scale_by_two_unit_macros.svh */
// Assertion macros used by the scaler job queue.
`ifndef IMAGE_SCALE_BY_TWO_UNIT_MACROS_SVH
`define IMAGE_SCALE_BY_TWO_UNIT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define IMSC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("image scaler assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define IMSC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("image scaler assertion failed");

`endif

/* sv/imsc_pkg.sv */
// Shared types and constants of the scale-by-two unit.
package imsc_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int HEIGHT_CAP = 1024;
	localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
	localparam int LINE_AW    = $clog2(LINE_DEPTH);
	localparam int CNT_W      = 10;
	localparam int DIM_W      = 11;
	localparam int PIX_W      = 8;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(MAX_WIDTH);
	localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(HEIGHT_CAP);

	// Configuration register indexes.
	typedef enum logic [1:0] {
		CFG_SCALE_MODE   = 2'd0,
		CFG_IMAGE_WIDTH  = 2'd1,
		CFG_IMAGE_HEIGHT = 2'd2
	} cfg_idx_t;

	// Scale mode codes.
	typedef enum logic {
		MODE_UP   = 1'b0,
		MODE_DOWN = 1'b1
	} mode_t;

	// Configuration handed from the top level to the front end.
	typedef struct packed {
		mode_t            mode;
		logic [DIM_W-1:0] width;
		logic [DIM_W-1:0] height;
		logic             restart;
	} cfg_t;

	// One queued job for the back end.
	typedef struct packed {
		logic             up;
		logic [PIX_W-1:0] pix;
		logic [CNT_W-1:0] row;
		logic [CNT_W-1:0] col;
	} job_t;

	// Queue status seen by both sides.
	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

endpackage

/* sv/imsc_fifo.sv */
// Short job queue between the front end and the back end.
`include "image_scale_by_two_unit_macros.svh"

module imsc_fifo import imsc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  job_t       push_job,
	input  logic       pop,
	output job_t       head_job,
	output fifo_stat_t stat
);

	job_t               mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_CW-1:0] count_q;

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + FIFO_CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - FIFO_CW'(1);
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	assign head_job   = mem_q[rd_ptr_q];
	assign stat.full  = (count_q == FIFO_CW'(FIFO_DEPTH));
	assign stat.empty = (count_q == '0);

	`IMSC_ASSERT_NOW(a_no_overflow, push, !stat.full)
	`IMSC_ASSERT_NOW(a_no_underflow, pop, !stat.empty)
	`IMSC_ASSERT_NEXT(a_count_up, push && !pop, count_q == $past(count_q) + FIFO_CW'(1))

endmodule

/* sv/imsc_front.sv */
// Front end: pixel intake, raster position, line store and job classification.
module imsc_front import imsc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic [PIX_W-1:0] pixel_in,
	input  logic             in_valid,
	output logic             in_stall,
	input  fifo_stat_t       fstat,
	output logic             push,
	output job_t             push_job
);

	logic [CNT_W-1:0] col_q;
	logic [CNT_W-1:0] row_q;
	logic [PIX_W-1:0] held_left_q;
	logic [8:0]       line_mem [LINE_DEPTH];

	logic             valid_s1;
	logic             up_s1;
	logic [PIX_W-1:0] pix_s1;
	logic [PIX_W-1:0] held_s1;
	logic [CNT_W-1:0] row_s1;
	logic [CNT_W-1:0] col_s1;
	logic [8:0]       upper_s1;

	logic             accept;
	logic             is_up;
	logic             produces;
	logic             line_we;
	logic             line_re;
	logic [LINE_AW-1:0] line_addr;
	logic [8:0]       pair_sum;
	logic [DIM_W-1:0] eff_w;
	logic [DIM_W-1:0] eff_h;
	logic [DIM_W-1:0] col_inc;
	logic [DIM_W-1:0] row_inc;
	logic [9:0]       box_sum;

	// Out-of-range dimensions are clamped to one and to the maximum.
	always_comb begin
		if (cfg.width == '0) begin
			eff_w = DIM_W'(1);
		end else if (cfg.width > DIM_W'(MAX_WIDTH)) begin
			eff_w = DIM_W'(MAX_WIDTH);
		end else begin
			eff_w = cfg.width;
		end
		if (cfg.height == '0) begin
			eff_h = DIM_W'(1);
		end else if (cfg.height > DIM_W'(HEIGHT_CAP)) begin
			eff_h = DIM_W'(HEIGHT_CAP);
		end else begin
			eff_h = cfg.height;
		end
	end

	// The input waits only while the stage register is full and the queue cannot take it.
	assign in_stall = valid_s1 && fstat.full;
	assign accept   = in_valid && !in_stall;
	assign is_up    = (cfg.mode == MODE_UP);
	assign produces = is_up || (col_q[0] && row_q[0]);

	// Line store access: even rows write pair sums, odd rows read them back.
	assign line_addr = col_q[LINE_AW:1];
	assign pair_sum  = {1'b0, held_left_q} + {1'b0, pixel_in};
	assign line_we   = accept && !is_up && col_q[0] && !row_q[0];
	assign line_re   = accept && !is_up && col_q[0] && row_q[0];

	always_ff @(posedge clk) begin
		if (line_we) begin
			line_mem[line_addr] <= pair_sum;
		end
		if (line_re) begin
			upper_s1 <= line_mem[line_addr];
		end
	end

	// Raster position, restarted by any write to a known configuration register.
	assign col_inc = {1'b0, col_q} + DIM_W'(1);
	assign row_inc = {1'b0, row_q} + DIM_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			held_left_q <= '0;
		end else if (cfg.restart) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (!is_up && !col_q[0]) begin
				held_left_q <= pixel_in;
			end
			if (col_inc >= eff_w) begin
				col_q <= '0;
				row_q <= (row_inc >= eff_h) ? '0 : row_inc[CNT_W-1:0];
			end else begin
				col_q <= col_inc[CNT_W-1:0];
			end
		end
	end

	// Stage register: holds an item that yields results until the queue takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= accept && produces;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			up_s1   <= is_up;
			pix_s1  <= pixel_in;
			held_s1 <= held_left_q;
			row_s1  <= row_q;
			col_s1  <= col_q;
		end
	end

	// Box average of the stored pair sum and the current pair, truncated.
	assign box_sum = {1'b0, upper_s1} + {2'b0, held_s1} + {2'b0, pix_s1};

	assign push         = valid_s1 && !fstat.full;
	assign push_job.up  = up_s1;
	assign push_job.pix = up_s1 ? pix_s1 : box_sum[9:2];
	assign push_job.row = row_s1;
	assign push_job.col = col_s1;

endmodule

/* sv/imsc_back.sv */
// Back end: expands queued jobs into target pixels behind an output register.
module imsc_back import imsc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  job_t             head_job,
	input  fifo_stat_t       fstat,
	output logic             pop,
	output logic [PIX_W-1:0] pixel_out,
	output logic [DIM_W-1:0] out_row,
	output logic [DIM_W-1:0] out_col,
	output logic             run_last,
	output logic             out_valid,
	input  logic             out_stall
);

	logic [1:0]       sub_q;
	logic             out_valid_q;
	logic [PIX_W-1:0] pix_q;
	logic [DIM_W-1:0] row_q;
	logic [DIM_W-1:0] col_q;
	logic             last_q;

	logic             load;
	logic             job_done;
	logic [DIM_W-1:0] next_row;
	logic [DIM_W-1:0] next_col;

	// The output register takes a new result when empty or when its transaction completes.
	assign load     = !fstat.empty && (!out_valid_q || !out_stall);
	assign job_done = !head_job.up || (sub_q == 2'd3);
	assign pop      = load && job_done;

	// Target position: a 2x2 block for upscale, half position for downscale.
	always_comb begin
		if (head_job.up) begin
			next_row = {head_job.row, sub_q[1]};
			next_col = {head_job.col, sub_q[0]};
		end else begin
			next_row = {2'b0, head_job.row[CNT_W-1:1]};
			next_col = {2'b0, head_job.col[CNT_W-1:1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				sub_q <= job_done ? 2'd0 : sub_q + 2'd1;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pix_q  <= head_job.pix;
			row_q  <= next_row;
			col_q  <= next_col;
			last_q <= job_done;
		end
	end

	assign out_valid = out_valid_q;
	assign pixel_out = pix_q;
	assign out_row   = row_q;
	assign out_col   = col_q;
	assign run_last  = last_q;

endmodule

/* sv/image_scale_by_two_unit.sv */
// Path: a pixel's first result passes the front-end stage register, the job queue and
// the output register. Downscale mode: one pixel per cycle while in_stall is low, set by
// the single line-store port. Upscale mode: each pixel yields four results, presented one
// result per cycle by the output register while out_stall is low.
// Reset: asynchronous, active low; clears counters, queue and handshake state and loads
// mode up, width 1024, height 1024. The line store is not cleared.
module image_scale_by_two_unit import imsc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [1:0]       cfg_index,
	input  logic [DIM_W-1:0] cfg_data,
	input  logic [PIX_W-1:0] pixel_in,
	input  logic             in_valid,
	output logic             in_stall,
	output logic [PIX_W-1:0] pixel_out,
	output logic [DIM_W-1:0] out_row,
	output logic [DIM_W-1:0] out_col,
	output logic             run_last,
	output logic             out_valid,
	input  logic             out_stall
);

	mode_t            mode_q;
	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	logic             cfg_wr;
	cfg_t             cfg;
	fifo_stat_t       fstat;
	logic             push;
	logic             pop;
	job_t             push_job;
	job_t             head_job;

	// Configuration registers; any known register write restarts the frame.
	assign cfg_ready = 1'b1;

	always_comb begin
		unique case (cfg_index)
			CFG_SCALE_MODE,
			CFG_IMAGE_WIDTH,
			CFG_IMAGE_HEIGHT: cfg_wr = cfg_valid;
			default:          cfg_wr = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_UP;
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_SCALE_MODE:   mode_q   <= mode_t'(cfg_data[0]);
				CFG_IMAGE_WIDTH:  width_q  <= cfg_data;
				CFG_IMAGE_HEIGHT: height_q <= cfg_data;
				default:          ;
			endcase
		end
	end

	assign cfg.mode    = mode_q;
	assign cfg.width   = width_q;
	assign cfg.height  = height_q;
	assign cfg.restart = cfg_wr;

	imsc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.pixel_in (pixel_in),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.fstat    (fstat),
		.push     (push),
		.push_job (push_job)
	);

	imsc_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head_job (head_job),
		.stat     (fstat)
	);

	imsc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_job  (head_job),
		.fstat     (fstat),
		.pop       (pop),
		.pixel_out (pixel_out),
		.out_row   (out_row),
		.out_col   (out_col),
		.run_last  (run_last),
		.out_valid (out_valid),
		.out_stall (out_stall)
	);

endmodule
